// ===== hdl/sm3_pkg.sv =====
package sm3_pkg;

   localparam logic [31:0] T_LOW  = 32'h79CC4519;
   localparam logic [31:0] T_HIGH = 32'h7A879D8A;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [3:0]  LEN_WORD_POS = 4'd14;

   typedef logic [7:0][31:0] cv_type;

   localparam cv_type SM3_IV = {32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
                                32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUT
   } state_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// ===== hdl/sm3_hash_engine.sv =====
// A word that does not end a block is stored in its slot of the window; a word
// that completes a block is followed by 64 rounds and one fold, done by the
// single round unit, and the next word is taken only after the fold. A final
// word adds padding, one or two compressions and eight digest transactions.
// Reset (synchronous, active high) loads the initial value and clears the length.
module sm3_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // message_word[31:0], last_bytes[34:32], zero fill
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[34:32], zero fill
   output logic        rsp_tlast    // is_final_word
);
   import sm3_pkg::*;

   state_type state_ff, state_in;
   cv_type cv_ff, cv_in;
   logic [7:0][31:0] wk_ff, wk_in;     // working variables a..h
   logic [15:0][31:0] win_ff, win_in;  // expansion window, w[j] at index 0
   logic [63:0] count_ff, count_in;
   logic [5:0]  round_ff, round_in;
   logic [3:0]  widx_ff, widx_in;      // next word slot of the block
   logic        final_ff, final_in;    // this compression is the last one
   logic        second_ff, second_in;  // a length-only block follows
   logic [2:0]  oidx_ff, oidx_in;

   logic        accept;
   logic [31:0] word, keep, padded;
   logic [2:0]  nb_raw, nb;
   logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wnew;
   logic [63:0] bits;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign word = req_tdata[31:0];
   assign nb_raw = req_tdata[34:32];
   assign nb = (nb_raw > 3'd4) ? 3'd4 : nb_raw;
   assign bits = count_ff << 3;

   // Round datapath, shared across all 64 rounds.
   always_comb begin
      tj  = rotl((round_ff < 6'd16) ? T_LOW : T_HIGH, round_ff[4:0]);
      a12 = rotl(wk_ff[0], 5'd12);
      ss1 = rotl(a12 + wk_ff[4] + tj, 5'd7);
      ss2 = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ff = wk_ff[0] ^ wk_ff[1] ^ wk_ff[2];
         gg = wk_ff[4] ^ wk_ff[5] ^ wk_ff[6];
      end else begin
         ff = (wk_ff[0] & wk_ff[1]) | (wk_ff[0] & wk_ff[2]) | (wk_ff[1] & wk_ff[2]);
         gg = (wk_ff[4] & wk_ff[5]) | (~wk_ff[4] & wk_ff[6]);
      end
      tt1 = ff + wk_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2 = gg + wk_ff[7] + ss1 + win_ff[0];
      wnew = perm1(win_ff[0] ^ win_ff[7] ^ rotl(win_ff[13], 5'd15))
           ^ rotl(win_ff[3], 5'd7) ^ win_ff[10];
   end

   // Final word with its padding byte.
   always_comb begin
      keep = (nb == 3'd0) ? 32'h0 : (32'hFFFFFFFF << (6'd32 - {nb, 3'b000}));
      padded = (word & keep) | ({24'h0, PAD_BYTE} << (5'd24 - {nb[1:0], 3'b000}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cv_ff <= SM3_IV;
         count_ff <= '0;
         widx_ff <= '0;
         round_ff <= '0;
         final_ff <= 1'b0;
         second_ff <= 1'b0;
         oidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         cv_ff <= cv_in;
         count_ff <= count_in;
         widx_ff <= widx_in;
         round_ff <= round_in;
         final_ff <= final_in;
         second_ff <= second_in;
         oidx_ff <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_ff <= wk_in;
      win_ff <= win_in;
   end

   // Sequencer: collect, pad, round, fold, emit.
   always_comb begin
      state_in = state_ff;
      cv_in = cv_ff;
      wk_in = wk_ff;
      win_in = win_ff;
      count_in = count_ff;
      round_in = round_ff;
      widx_in = widx_ff;
      final_in = final_ff;
      second_in = second_ff;
      oidx_in = oidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wk_in = cv_ff;
               round_in = '0;
               if (!req_tlast) begin
                  win_in[widx_ff] = word;
                  count_in = count_ff + 64'd4;
                  widx_in = widx_ff + 4'd1;
                  final_in = 1'b0;
                  if (widx_ff == 4'd15) state_in = ST_ROUND;
               end else begin
                  count_in = count_ff + {61'd0, nb};
                  final_in = 1'b0;
                  second_in = 1'b0;
                  if (nb == 3'd4) begin
                     win_in[widx_ff] = word;
                     if (widx_ff == 4'd15) begin
                        // Block full: the padding byte leads a new length block.
                        second_in = 1'b1;
                        widx_in = 4'd1;
                        state_in = ST_ROUND;
                     end else begin
                        win_in[widx_ff + 4'd1] = {PAD_BYTE, 24'h0};
                        if (widx_ff == 4'd14) begin
                           // The padding word fills the block: a bare length block follows.
                           second_in = 1'b1;
                           widx_in = 4'd0;
                           state_in = ST_ROUND;
                        end else begin
                           widx_in = widx_ff + 4'd2;
                           state_in = ST_PAD;
                        end
                     end
                  end else begin
                     win_in[widx_ff] = padded;
                     if (widx_ff == 4'd15) begin
                        // The padded word fills the block: a bare length block follows.
                        second_in = 1'b1;
                        widx_in = 4'd0;
                        state_in = ST_ROUND;
                     end else begin
                        widx_in = widx_ff + 4'd1;
                        state_in = ST_PAD;
                     end
                  end
               end
            end
         end
         ST_PAD: begin
            wk_in = cv_ff;
            round_in = '0;
            if (second_ff) begin
               // Length-only block; slot 1 as next slot means the padding word leads it.
               for (int i = 0; i < 16; i++) win_in[i] = '0;
               if (widx_ff == 4'd1) win_in[0] = {PAD_BYTE, 24'h0};
               win_in[14] = bits[63:32];
               win_in[15] = bits[31:0];
               second_in = 1'b0;
               final_in = 1'b1;
            end else begin
               // Zero fill behind the padding word.
               for (int i = 0; i < 16; i++) begin
                  if (i >= int'(widx_ff)) win_in[i] = '0;
               end
               if (widx_ff > LEN_WORD_POS) begin
                  // No room for the length: it goes to a block of its own.
                  final_in = 1'b0;
                  second_in = 1'b1;
               end else begin
                  win_in[14] = bits[63:32];
                  win_in[15] = bits[31:0];
                  final_in = 1'b1;
               end
            end
            widx_in = 4'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            wk_in[0] = tt1;
            wk_in[1] = wk_ff[0];
            wk_in[2] = rotl(wk_ff[1], 5'd9);
            wk_in[3] = wk_ff[2];
            wk_in[4] = perm0(tt2);
            wk_in[5] = wk_ff[4];
            wk_in[6] = rotl(wk_ff[5], 5'd19);
            wk_in[7] = wk_ff[6];
            for (int i = 0; i < 15; i++) win_in[i] = win_ff[i + 1];
            win_in[15] = wnew;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cv_in = cv_ff ^ wk_ff;
            if (final_ff) begin
               oidx_in = '0;
               state_in = ST_OUT;
            end else if (second_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  cv_in = SM3_IV;
                  count_in = '0;
                  widx_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = {5'd0, oidx_ff, cv_ff[oidx_ff]};
   assign rsp_tlast = (oidx_ff == 3'd7);

endmodule

// ===== hdl/sm3_hash_engine_checker.sv =====
module sm3_hash_engine_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   // The engine never takes input while a digest is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("input ready during output");

   // The last-word flag marks index seven.
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7))) else $error("bad tlast");

   // Indices advance by one per transaction.
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid &&
      rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1) else $error("index skip");

   // After the final digest word the engine returns to ready.
   a_back_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready) else $error("not idle");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("drop");
endmodule

bind sm3_hash_engine sm3_hash_engine_checker u_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
